// File: rtl/core/ctos_pkg.sv
`default_nettype none

package ctos_pkg;

    localparam int COORD_WIDTH       = 16;
    localparam int ANGLE_WIDTH       = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // CORDIC datapath: coordinates carry GUARD_BITS fraction bits plus growth headroom
    localparam int GUARD_BITS = 24;
    localparam int VEC_WIDTH  = COORD_WIDTH + GUARD_BITS + 3;
    // angle accumulator: 2^32 units per turn, two bits of headroom
    localparam int ACC_WIDTH  = 34;
    localparam int SQ_WIDTH   = 2 * COORD_WIDTH;

    localparam logic [29:0] INV_GAIN = 30'h26DD3B6A;
    localparam logic signed [ACC_WIDTH-1:0] HALF_TURN = 34'sd2147483648;
    localparam logic [32:0] ANGLE_HALF = (33'd1 << (32 - ANGLE_WIDTH)) >> 1;

    // atan(2^-i) in 2^32 units per turn
    localparam logic [31:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
        logic signed [COORD_WIDTH-1:0] z_coord;
    } point_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0]        radius;
        logic [ANGLE_WIDTH-1:0]        polar_angle;
        logic signed [ANGLE_WIDTH-1:0] azimuth;
    } sphere_t;

    // carried alongside the azimuth pass
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] z_coord;
        logic [COORD_WIDTH-1:0]        radius;
        logic                          nz_xy;
    } az_side_t;

    // carried alongside the polar pass
    typedef struct packed {
        logic signed [ACC_WIDTH-1:0] azim_acc;
        logic [COORD_WIDTH-1:0]      radius;
        logic                        nz_xy;
        logic                        z_neg;
    } pol_side_t;

endpackage

`default_nettype wire

// File: rtl/core/ctos_sqrt.sv
`default_nettype none

module ctos_sqrt #(
    parameter int N_WIDTH    = 32,
    parameter int SIDE_WIDTH = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [N_WIDTH-1:0]          radicand,
    input  logic [SIDE_WIDTH-1:0]       in_side,
    output logic                        out_valid,
    output logic [(N_WIDTH+1)/2:0]      root,
    output logic [SIDE_WIDTH-1:0]       out_side
);

    localparam int R_WIDTH  = (N_WIDTH + 1) / 2;
    localparam int RP_WIDTH = R_WIDTH + 1;
    localparam int T_WIDTH  = 2 * R_WIDTH + 1;

    logic [N_WIDTH-1:0]    rem_reg  [R_WIDTH];
    logic [R_WIDTH-1:0]    q_reg    [R_WIDTH];
    logic [SIDE_WIDTH-1:0] side_reg [R_WIDTH];
    logic                  vld_reg  [R_WIDTH];

    logic                  out_vld_reg;
    logic [RP_WIDTH-1:0]   root_reg;
    logic [SIDE_WIDTH-1:0] out_side_reg;
    logic                  round_up;

    // one root bit per stage, most significant first
    for (genvar k = 0; k < R_WIDTH; k++) begin : g_digit
        localparam int J = R_WIDTH - 1 - k;
        logic [N_WIDTH-1:0]    rem_in;
        logic [R_WIDTH-1:0]    q_in;
        logic [SIDE_WIDTH-1:0] side_in;
        logic                  vld_in;
        logic [T_WIDTH-1:0]    trial;
        logic                  fits;

        if (k == 0) begin : g_first
            assign rem_in  = radicand;
            assign q_in    = '0;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        // (q + 2^J)^2 - q^2 = q*2^(J+1) + 2^(2J)
        assign trial = (T_WIDTH'(q_in) << (J + 1)) + (T_WIDTH'(1) << (2 * J));
        assign fits  = T_WIDTH'(rem_in) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= fits ? N_WIDTH'(T_WIDTH'(rem_in) - trial) : rem_in;
                q_reg[k]    <= fits ? (q_in | (R_WIDTH'(1) << J)) : q_in;
                side_reg[k] <= side_in;
            end
        end
    end

    // round to nearest: remainder above root means n is past (root + 1/2)^2
    assign round_up = rem_reg[R_WIDTH-1] > N_WIDTH'(q_reg[R_WIDTH-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_reg[R_WIDTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg     <= RP_WIDTH'(q_reg[R_WIDTH-1]) + RP_WIDTH'(round_up);
            out_side_reg <= side_reg[R_WIDTH-1];
        end
    end

    assign out_valid = out_vld_reg;
    assign root      = root_reg;
    assign out_side  = out_side_reg;

endmodule

`default_nettype wire

// File: rtl/core/ctos_vec.sv
`default_nettype none

module ctos_vec #(
    parameter int STAGES     = 16,
    parameter int SIDE_WIDTH = 33
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [ctos_pkg::VEC_WIDTH-1:0] in_x,
    input  logic signed [ctos_pkg::VEC_WIDTH-1:0] in_y,
    input  logic signed [ctos_pkg::ACC_WIDTH-1:0] in_acc,
    input  logic [SIDE_WIDTH-1:0]                in_side,
    output logic                                 out_valid,
    output logic signed [ctos_pkg::VEC_WIDTH-1:0] out_x,
    output logic signed [ctos_pkg::ACC_WIDTH-1:0] out_acc,
    output logic [SIDE_WIDTH-1:0]                out_side
);

    import ctos_pkg::*;

    logic signed [VEC_WIDTH-1:0] x_reg    [STAGES];
    logic signed [VEC_WIDTH-1:0] y_reg    [STAGES-1];
    logic signed [ACC_WIDTH-1:0] acc_reg  [STAGES];
    logic [SIDE_WIDTH-1:0]       side_reg [STAGES];
    logic                        vld_reg  [STAGES];

    // vectoring: rotate toward y = 0, one micro-rotation per stage
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic signed [ACC_WIDTH-1:0] ANG = ACC_WIDTH'(ATAN_TURN[k]);
        logic signed [VEC_WIDTH-1:0] x_in;
        logic signed [VEC_WIDTH-1:0] y_in;
        logic signed [VEC_WIDTH-1:0] dx;
        logic signed [VEC_WIDTH-1:0] dy;
        logic signed [ACC_WIDTH-1:0] acc_in;
        logic [SIDE_WIDTH-1:0]       side_in;
        logic                        vld_in;
        logic                        y_neg;

        if (k == 0) begin : g_first
            assign x_in    = in_x;
            assign y_in    = in_y;
            assign acc_in  = in_acc;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_next
            assign x_in    = x_reg[k-1];
            assign y_in    = y_reg[k-1];
            assign acc_in  = acc_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        assign dx    = y_in >>> k;
        assign dy    = x_in >>> k;
        assign y_neg = y_in[VEC_WIDTH-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= y_neg ? (x_in - dx) : (x_in + dx);
                acc_reg[k]  <= y_neg ? (acc_in - ANG) : (acc_in + ANG);
                side_reg[k] <= side_in;
            end
        end

        if (k < STAGES - 1) begin : g_y
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    y_reg[k] <= y_neg ? (y_in + dy) : (y_in - dy);
                end
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_x     = x_reg[STAGES-1];
    assign out_acc   = acc_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

`default_nettype wire

// File: rtl/core/cartesian_to_spherical_top.sv
`default_nettype none

// channel  dir  handshake                    word
// point    in   point_valid / point_stall    point_t  {x_coord, y_coord, z_coord}
// sphere   out  sphere_valid / sphere_stall  sphere_t {radius, polar_angle, azimuth}
//
// One word accepted per cycle, sustained while point_stall is low.
// Each word passes through the square-root digit stages followed by the azimuth
// and polar CORDIC passes.
// Reset clears the valid bits and the output buffer's valid and full flags only.
// point_stall is the registered skid-full flag: while sphere_stall holds a full
// output register, the next result is parked in the skid register and the pipeline freezes until it drains.

module cartesian_to_spherical_top #(
    parameter int CORDIC_STAGES = ctos_pkg::CORDIC_STAGES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              point_valid,
    output logic              point_stall,
    input  ctos_pkg::point_t  point,
    output logic              sphere_valid,
    input  logic              sphere_stall,
    output ctos_pkg::sphere_t sphere
);

    import ctos_pkg::*;

    localparam int HI_WIDTH      = VEC_WIDTH - 32;
    localparam int HI_PROD_WIDTH = HI_WIDTH + 30;
    localparam int LO_PROD_WIDTH = 62;

    logic adv;

    // front: squares
    logic                       front_vld_reg;
    point_t                     front_pt_reg;
    logic signed [SQ_WIDTH-1:0] sqx, sqy, sqz;
    logic [SQ_WIDTH-1:0]        sqx_reg, sqy_reg, sqz_reg;

    // sum of squares
    logic                sum_vld_reg;
    point_t              sum_pt_reg;
    logic [SQ_WIDTH-1:0] sum_reg;

    // square root
    logic                   rt_vld;
    logic [COORD_WIDTH:0]   rt_root;
    point_t                 rt_pt;

    // azimuth pass setup
    logic signed [VEC_WIDTH-1:0] xe, ye;
    logic                        x_neg;
    logic                        p1_vld_reg;
    logic signed [VEC_WIDTH-1:0] p1_x_reg, p1_y_reg;
    logic signed [ACC_WIDTH-1:0] p1_acc_reg;
    az_side_t                    p1_side_reg;

    logic                        az_vld;
    logic signed [VEC_WIDTH-1:0] az_x;
    logic signed [ACC_WIDTH-1:0] az_acc;
    az_side_t                    az_side;

    // inverse gain multiply, split in two partial products
    logic                        ma_vld_reg;
    logic [LO_PROD_WIDTH-1:0]    lo_prod_reg;
    logic [HI_PROD_WIDTH-1:0]    hi_prod_reg;
    logic signed [ACC_WIDTH-1:0] ma_acc_reg;
    az_side_t                    ma_side_reg;

    logic                        mb_vld_reg;
    logic signed [VEC_WIDTH-1:0] rho_reg;
    logic signed [ACC_WIDTH-1:0] mb_acc_reg;
    az_side_t                    mb_side_reg;

    // polar pass setup
    logic signed [VEC_WIDTH-1:0] ze;
    logic                        z_neg;
    logic                        p2_vld_reg;
    logic signed [VEC_WIDTH-1:0] p2_x_reg, p2_y_reg;
    logic signed [ACC_WIDTH-1:0] p2_acc_reg;
    pol_side_t                   p2_side_reg;

    logic                        pol_vld;
    logic signed [ACC_WIDTH-1:0] pol_acc;
    pol_side_t                   pol_side;

    // result formatting
    logic signed [ACC_WIDTH-1:0] pol_sel, az_sel;
    logic [32:0]                 pol_sum, az_sum;
    sphere_t                     res;

    // output buffer
    logic    out_vld_reg, out_vld_next;
    logic    skid_full_reg, skid_full_next;
    sphere_t out_reg, skid_reg;
    logic    out_take, out_load, skid_load, skid_move;

    assign adv = !skid_full_reg;

    // ---------------------------------------------------------------- front
    assign sqx = SQ_WIDTH'(point.x_coord) * SQ_WIDTH'(point.x_coord);
    assign sqy = SQ_WIDTH'(point.y_coord) * SQ_WIDTH'(point.y_coord);
    assign sqz = SQ_WIDTH'(point.z_coord) * SQ_WIDTH'(point.z_coord);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= 1'b0;
            sum_vld_reg   <= 1'b0;
            p1_vld_reg    <= 1'b0;
            ma_vld_reg    <= 1'b0;
            mb_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
        end
        else if (adv)
        begin
            front_vld_reg <= point_valid;
            sum_vld_reg   <= front_vld_reg;
            p1_vld_reg    <= rt_vld;
            ma_vld_reg    <= az_vld;
            mb_vld_reg    <= ma_vld_reg;
            p2_vld_reg    <= mb_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front_pt_reg <= point;
            sqx_reg      <= $unsigned(sqx);
            sqy_reg      <= $unsigned(sqy);
            sqz_reg      <= $unsigned(sqz);
            sum_pt_reg   <= front_pt_reg;
            sum_reg      <= sqx_reg + sqy_reg + sqz_reg;
        end
    end

    ctos_sqrt #(
        .N_WIDTH    (SQ_WIDTH),
        .SIDE_WIDTH ($bits(point_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sum_vld_reg),
        .radicand  (sum_reg),
        .in_side   (sum_pt_reg),
        .out_valid (rt_vld),
        .root      (rt_root),
        .out_side  (rt_pt)
    );

    // ---------------------------------------------------------------- azimuth
    assign xe    = VEC_WIDTH'(rt_pt.x_coord) <<< GUARD_BITS;
    assign ye    = VEC_WIDTH'(rt_pt.y_coord) <<< GUARD_BITS;
    assign x_neg = rt_pt.x_coord[COORD_WIDTH-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // left half plane: turn by pi first
            p1_x_reg            <= x_neg ? -xe : xe;
            p1_y_reg            <= x_neg ? -ye : ye;
            p1_acc_reg          <= x_neg ? HALF_TURN : '0;
            p1_side_reg.z_coord <= rt_pt.z_coord;
            p1_side_reg.radius  <= rt_root[COORD_WIDTH-1:0];
            p1_side_reg.nz_xy   <= (rt_pt.x_coord != '0) || (rt_pt.y_coord != '0);
        end
    end

    ctos_vec #(
        .STAGES     (CORDIC_STAGES),
        .SIDE_WIDTH ($bits(az_side_t))
    ) u_vec_az (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p1_vld_reg),
        .in_x      (p1_x_reg),
        .in_y      (p1_y_reg),
        .in_acc    (p1_acc_reg),
        .in_side   (p1_side_reg),
        .out_valid (az_vld),
        .out_x     (az_x),
        .out_acc   (az_acc),
        .out_side  (az_side)
    );

    // ---------------------------------------------------------------- gain
    // az_x is never negative: rho = hi*c*4 + floor(lo*c / 2^30)
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_prod_reg <= LO_PROD_WIDTH'(az_x[31:0]) * LO_PROD_WIDTH'(INV_GAIN);
            hi_prod_reg <= HI_PROD_WIDTH'(az_x[VEC_WIDTH-1:32]) * HI_PROD_WIDTH'(INV_GAIN);
            ma_acc_reg  <= az_acc;
            ma_side_reg <= az_side;
            rho_reg     <= $signed(VEC_WIDTH'({hi_prod_reg, 2'b00})
                                   + VEC_WIDTH'(lo_prod_reg[LO_PROD_WIDTH-1:30]));
            mb_acc_reg  <= ma_acc_reg;
            mb_side_reg <= ma_side_reg;
        end
    end

    // ---------------------------------------------------------------- polar
    assign ze    = VEC_WIDTH'(mb_side_reg.z_coord) <<< GUARD_BITS;
    assign z_neg = mb_side_reg.z_coord[COORD_WIDTH-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_x_reg             <= z_neg ? -ze : ze;
            p2_y_reg             <= z_neg ? -rho_reg : rho_reg;
            p2_acc_reg           <= z_neg ? HALF_TURN : '0;
            p2_side_reg.azim_acc <= mb_acc_reg;
            p2_side_reg.radius   <= mb_side_reg.radius;
            p2_side_reg.nz_xy    <= mb_side_reg.nz_xy;
            p2_side_reg.z_neg    <= z_neg;
        end
    end

    ctos_vec #(
        .STAGES     (CORDIC_STAGES),
        .SIDE_WIDTH ($bits(pol_side_t))
    ) u_vec_pol (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p2_vld_reg),
        .in_x      (p2_x_reg),
        .in_y      (p2_y_reg),
        .in_acc    (p2_acc_reg),
        .in_side   (p2_side_reg),
        .out_valid (pol_vld),
        .out_x     (),
        .out_acc   (pol_acc),
        .out_side  (pol_side)
    );

    // ---------------------------------------------------------------- format
    always_comb
    begin
        if (!pol_side.nz_xy)
        begin
            // on the z axis or at the origin
            pol_sel = pol_side.z_neg ? HALF_TURN : '0;
            az_sel  = '0;
        end
        else
        begin
            if (pol_acc < 0)
            begin
                pol_sel = '0;
            end
            else if (pol_acc > HALF_TURN)
            begin
                pol_sel = HALF_TURN;
            end
            else
            begin
                pol_sel = pol_acc;
            end
            az_sel = pol_side.azim_acc;
        end
    end

    assign pol_sum = {1'b0, pol_sel[31:0]} + ANGLE_HALF;
    assign az_sum  = {1'b0, az_sel[31:0]} + ANGLE_HALF;

    assign res.radius      = pol_side.radius;
    assign res.polar_angle = pol_sum[31 -: ANGLE_WIDTH];
    assign res.azimuth     = $signed(az_sum[31 -: ANGLE_WIDTH]);

    // ---------------------------------------------------------------- output
    assign out_take = out_vld_reg && !sphere_stall;

    always_comb
    begin
        out_vld_next   = out_vld_reg;
        skid_full_next = skid_full_reg;
        out_load       = 1'b0;
        skid_load      = 1'b0;
        skid_move      = 1'b0;
        if (skid_full_reg)
        begin
            if (out_take)
            begin
                skid_move      = 1'b1;
                skid_full_next = 1'b0;
            end
        end
        else if (pol_vld)
        begin
            if (!out_vld_reg || out_take)
            begin
                out_load     = 1'b1;
                out_vld_next = 1'b1;
            end
            else
            begin
                skid_load      = 1'b1;
                skid_full_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg   <= out_vld_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res;
        end
        else if (skid_move)
        begin
            out_reg <= skid_reg;
        end
        if (skid_load)
        begin
            skid_reg <= res;
        end
    end

    assign point_stall  = skid_full_reg;
    assign sphere_valid = out_vld_reg;
    assign sphere       = out_reg;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_vld_reg)
        else $error("skid word held with no word in the output register");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_full_reg && out_take) |=> (out_vld_reg && !skid_full_reg))
        else $error("skid word lost on drain");

    a_polar_range: assert property (@(posedge clk) disable iff (!rst_n)
        sphere_valid |-> (!sphere.polar_angle[ANGLE_WIDTH-1]
                          || (sphere.polar_angle[ANGLE_WIDTH-2:0] == '0)))
        else $error("polar angle beyond half a turn");
`endif

endmodule

`default_nettype wire

// File: bench/tb_cartesian_to_spherical_top.sv
`default_nettype none

module tb_cartesian_to_spherical_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ctos_pkg::*;

    localparam int  LATENCY     = COORD_WIDTH + 2 * CORDIC_STAGES_DEF + 8;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  MAX_REPORTS = 10;
    localparam longint PI_TURN  = 64'sd2147483648;

    logic    clk;
    logic    rst_n;
    logic    point_valid;
    logic    point_stall;
    point_t  point;
    logic    sphere_valid;
    logic    sphere_stall;
    sphere_t sphere;

    sphere_t sphere_q[$];
    int      mismatches;
    int      cycles;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_left;

    cartesian_to_spherical_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .sphere_valid (sphere_valid),
        .sphere_stall (sphere_stall),
        .sphere       (sphere)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // CORDIC vectoring: drives vy toward zero, returns the accumulated angle
    function automatic longint cordic_vector(inout longint vx, input longint vy,
                                             input longint acc);
        longint dx;
        longint dy;
        for (int i = 0; i < CORDIC_STAGES_DEF && i < 32; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx  = vx + dx;
                vy  = vy - dy;
                acc = acc + longint'(ATAN_TURN[i]);
            end
            else
            begin
                vx  = vx - dx;
                vy  = vy + dy;
                acc = acc - longint'(ATAN_TURN[i]);
            end
        end
        return acc;
    endfunction

    function automatic longint rounded_root(longint n);
        longint r;
        longint t;
        r = 0;
        for (int b = 17; b >= 0; b--)
        begin
            t = r | (longint'(1) << b);
            if (t * t <= n)
                r = t;
        end
        if (n - r * r > r)
            r = r + 1;
        return r;
    endfunction

    function automatic logic [ANGLE_WIDTH-1:0] to_bangle(longint acc);
        logic [32:0] u;
        u = {1'b0, acc[31:0]} + ANGLE_HALF;
        return u[31 -: ANGLE_WIDTH];
    endfunction

    function automatic sphere_t to_sphere(point_t p);
        longint x, y, z;
        longint cx, cy, cz;
        longint rho, azim, polar, acc;
        logic [127:0] prod;
        sphere_t s;
        x = longint'(p.x_coord);
        y = longint'(p.y_coord);
        z = longint'(p.z_coord);
        s.radius = COORD_WIDTH'(rounded_root(x * x + y * y + z * z));
        azim  = 0;
        polar = 0;
        if (x != 0 || y != 0)
        begin
            cx  = x * (longint'(1) << GUARD_BITS);
            cy  = y * (longint'(1) << GUARD_BITS);
            acc = 0;
            if (cx < 0)
            begin
                cx  = -cx;
                cy  = -cy;
                acc = PI_TURN;
            end
            azim = cordic_vector(cx, cy, acc);
            prod = {64'b0, cx} * {98'b0, INV_GAIN};
            rho  = longint'(prod >> 30);
            cz   = z * (longint'(1) << GUARD_BITS);
            acc  = 0;
            if (cz < 0)
            begin
                cz  = -cz;
                rho = -rho;
                acc = PI_TURN;
            end
            polar = cordic_vector(cz, rho, acc);
            if (polar < 0)
                polar = 0;
            if (polar > PI_TURN)
                polar = PI_TURN;
        end
        else if (z < 0)
        begin
            polar = PI_TURN;
        end
        s.polar_angle = to_bangle(polar);
        s.azimuth     = to_bangle(azim);
        return s;
    endfunction

    // one input word; returns once accepted
    task automatic send_point(point_t p);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            point_valid <= 1'b0;
            @(negedge clk);
        end
        point_valid <= 1'b1;
        point       <= p;
        do
            @(posedge clk);
        while (point_stall);
        sphere_q.push_back(to_sphere(p));
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        point_valid <= 1'b0;
        while (sphere_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
        logic signed [COORD_WIDTH-1:0] c;
        case ($urandom_range(0, 9))
            5: c = COORD_WIDTH'($urandom_range(0, 16) - 8);
            6:
            begin
                case ($urandom_range(0, 5))
                    0: c = 16'sh8000;
                    1: c = 16'sh8001;
                    2: c = -16'sd1;
                    3: c = 16'sd0;
                    4: c = 16'sd1;
                    default: c = 16'sh7FFF;
                endcase
            end
            7: c = '0;
            8, 9: c = COORD_WIDTH'($urandom_range(0, 2047) - 1024);
            default: c = COORD_WIDTH'($urandom());
        endcase
        return c;
    endfunction

    function automatic point_t rand_point();
        point_t p;
        p.x_coord = rand_coord();
        p.y_coord = rand_coord();
        p.z_coord = rand_coord();
        return p;
    endfunction

    task automatic send_xyz(int x, int y, int z);
        point_t p;
        p.x_coord = COORD_WIDTH'(x);
        p.y_coord = COORD_WIDTH'(y);
        p.z_coord = COORD_WIDTH'(z);
        send_point(p);
    endtask

    task automatic test_directed_points();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_xyz(0, 0, 0);
        send_xyz(0, 0, 1);
        send_xyz(0, 0, -1);
        send_xyz(0, 0, 32767);
        send_xyz(0, 0, -32768);
        send_xyz(32767, 32767, 32767);
        send_xyz(-32768, -32768, -32768);
        send_xyz(-32768, 32767, -32768);
        send_xyz(32767, -32768, 0);
        send_xyz(-32768, 0, 0);
        send_xyz(-1, 0, 0);
        send_xyz(-5, 0, 3);
        send_xyz(0, -32768, 0);
        send_xyz(32767, 0, 0);
        send_xyz(0, 1, 0);
        send_xyz(0, -1, 0);
        send_xyz(1, 1, 1);
        send_xyz(-1, -1, -1);
        send_xyz(1, 0, 32767);
        send_xyz(0, 1, -32767);
        send_xyz(1, 0, -1);
        send_xyz(-3, 4, 0);
        wait_all_results();
    endtask

    task automatic test_random_points(int s_pct, int r_pct, int n);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n; i++)
            send_point(rand_point());
        wait_all_results();
    endtask

    // long output hold while input keeps coming: pipeline fills, input stalls
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge clk);
        hold_left = 200;
        for (int i = 0; i < 150; i++)
            send_point(rand_point());
        wait_all_results();
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            sphere_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else
        begin
            sphere_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sphere_valid && !sphere_stall)
        begin
            if (sphere_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected sphere word r=%0d p=%0d a=%0d",
                             sphere.radius, sphere.polar_angle, sphere.azimuth);
            end
            else
            begin
                sphere_t want;
                want = sphere_q.pop_front();
                if (sphere.radius !== want.radius
                    || sphere.polar_angle !== want.polar_angle
                    || sphere.azimuth !== want.azimuth)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: exp r=%0d p=%0d a=%0d  got r=%0d p=%0d a=%0d",
                                 want.radius, want.polar_angle, want.azimuth,
                                 sphere.radius, sphere.polar_angle, sphere.azimuth);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        point_valid   = 1'b0;
        point         = '0;
        sphere_stall  = 1'b0;
        mismatches    = 0;
        cycles        = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_points();
        test_random_points(32, 86, 560);
        test_random_points(86, 32, 560);
        test_random_points(0, 0, 560);
        test_backpressure();

        repeat (LATENCY + 16) @(posedge clk);
        if (sphere_q.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
